/* rtl/core/rc4_pkg.sv */
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int MAX_KEY_BYTES = 32;
  localparam int KIDX_W        = $clog2(MAX_KEY_BYTES);
  localparam int KEY_WORD_W    = 64;
  localparam int KEY_WORDS     = (MAX_KEY_BYTES * 8) / KEY_WORD_W;
  localparam int KEY_LEN_W     = 6;
  localparam int TAB_DEPTH     = 256;
  localparam int TAB_AW        = $clog2(TAB_DEPTH);
  localparam int CNT_W         = TAB_AW + 1;
  localparam int CFG_IDX_W     = 3;

  localparam logic [7:0]           BURN_VALUE    = 8'hFF;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_W0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_W1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_W2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_W3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 3'd4;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_SCHEDULE,
    KIND_REWIND,
    KIND_BURN
  } kind_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_D_RDI,
    OP_D_RDJ,
    OP_D_WRI,
    OP_D_WRJ,
    OP_FILL_ID,
    OP_FILL_FF,
    OP_COPY,
    OP_K_RDN,
    OP_K_RDJ,
    OP_K_WRN,
    OP_K_WRJ
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   cnt_clr;
    logic   cnt_inc;
    logic   idx_clr;
    logic   out_new;
    logic   out_held;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic cnt_done;
  } dp_stat_t;

endpackage

/* rtl/core/rc4_stream_cipher.sv */
`timescale 1ns / 1ps

// Channel   Dir  Signals                              Payload
// in_       in   in_tvalid/in_tready/in_tdata/in_tuser data byte, kind
// out_      out  out_tvalid/out_tready/out_tdata     data XOR keystream
// cfg_      in   cfg_we/cfg_index/cfg_wdata           key words, key length
//
// Data byte: accept, read S[j], write S[i], write S[j] and pick S[t]; a busy output adds
// a wait state. Data before keying is accepted and dropped. Schedule: fill, key swaps;
// rewind: copy the saved table back and clear i, j; burn: fill both tables with FF.
// Reset clears indices, keyed flag, key words and output valid; tables are not cleared.
// A result waits in the output register; a further result waits in a holding stage.

module rc4_stream_cipher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] data_byte
  input  logic [1:0]                    in_tuser,   // [1:0] kind
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] out_byte
  input  logic                          cfg_we,
  input  logic [rc4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rc4_pkg::KEY_WORD_W-1:0] cfg_wdata
);

  rc4_pkg::dp_cmd_t  cmd;
  rc4_pkg::dp_stat_t stat;

  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (rc4_pkg::kind_t'(in_tuser)),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  rc4_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_tdata),
    .out_byte (out_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  a_ready_dp_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (cmd.op == rc4_pkg::OP_NONE || cmd.op == rc4_pkg::OP_D_RDI))
    else $error("datapath busy while accepting a transaction");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.op == rc4_pkg::OP_D_WRJ))
    else $error("result raised without a keystream step");

  a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == rc4_pkg::OP_D_RDI) |=> !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("transaction accepted during a keystream step");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_new |-> (!out_tvalid || out_tready))
    else $error("output register overwritten before transfer");

endmodule

/* rtl/core/rc4_ram.sv */
`timescale 1ns / 1ps

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/rc4_ctrl.sv */
`timescale 1ns / 1ps

module rc4_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  rc4_pkg::kind_t    in_kind,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output rc4_pkg::dp_cmd_t  cmd,
  input  rc4_pkg::dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_D_RDJ,
    S_D_WRI,
    S_D_WRJ,
    S_D_WAIT,
    S_FILL,
    S_BURN,
    S_COPY,
    S_K_RDN,
    S_K_RDJ,
    S_K_WRN,
    S_K_WRJ
  } state_t;

  state_t state_r, state_nxt;
  logic   keyed_r, keyed_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    keyed_nxt     = keyed_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.op        = rc4_pkg::OP_NONE;
    cmd.cnt_clr   = 1'b0;
    cmd.cnt_inc   = 1'b0;
    cmd.idx_clr   = 1'b0;
    cmd.out_new   = 1'b0;
    cmd.out_held  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_kind)
            rc4_pkg::KIND_DATA: begin
              if (keyed_r) begin
                cmd.op    = rc4_pkg::OP_D_RDI;
                state_nxt = S_D_RDJ;
              end
            end
            rc4_pkg::KIND_SCHEDULE: begin
              cmd.cnt_clr = 1'b1;
              state_nxt   = S_FILL;
            end
            rc4_pkg::KIND_REWIND: begin
              cmd.cnt_clr = 1'b1;
              state_nxt   = S_COPY;
            end
            default: begin
              cmd.cnt_clr = 1'b1;
              state_nxt   = S_BURN;
            end
          endcase
        end
      end
      S_D_RDJ: begin
        cmd.op    = rc4_pkg::OP_D_RDJ;
        state_nxt = S_D_WRI;
      end
      S_D_WRI: begin
        cmd.op    = rc4_pkg::OP_D_WRI;
        state_nxt = S_D_WRJ;
      end
      S_D_WRJ: begin
        cmd.op = rc4_pkg::OP_D_WRJ;
        if (out_free) begin
          cmd.out_new   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_D_WAIT;
        end
      end
      S_D_WAIT: begin
        if (out_tready) begin
          cmd.out_held  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FILL: begin
        cmd.op      = rc4_pkg::OP_FILL_ID;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_K_RDN;
        end
      end
      S_BURN: begin
        cmd.op      = rc4_pkg::OP_FILL_FF;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_COPY: begin
        cmd.op      = rc4_pkg::OP_COPY;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_done) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_K_RDN: begin
        cmd.op    = rc4_pkg::OP_K_RDN;
        state_nxt = S_K_RDJ;
      end
      S_K_RDJ: begin
        cmd.op    = rc4_pkg::OP_K_RDJ;
        state_nxt = S_K_WRN;
      end
      S_K_WRN: begin
        cmd.op    = rc4_pkg::OP_K_WRN;
        state_nxt = S_K_WRJ;
      end
      S_K_WRJ: begin
        cmd.op      = rc4_pkg::OP_K_WRJ;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last) begin
          cmd.idx_clr = 1'b1;
          keyed_nxt   = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_K_RDN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      keyed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      keyed_r     <= keyed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/core/rc4_dp.sv */
`timescale 1ns / 1ps

module rc4_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rc4_pkg::dp_cmd_t                  cmd,
  output rc4_pkg::dp_stat_t                 stat,
  input  logic [7:0]                        in_data,
  output logic [7:0]                        out_byte,
  input  logic                              cfg_we,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rc4_pkg::KEY_WORD_W-1:0]    cfg_wdata
);

  localparam int AW = rc4_pkg::TAB_AW;
  localparam int KW = rc4_pkg::KIDX_W;

  logic [rc4_pkg::KEY_WORDS-1:0][rc4_pkg::KEY_WORD_W-1:0] key_r;
  logic [rc4_pkg::KEY_LEN_W-1:0] key_len_r;
  logic [rc4_pkg::MAX_KEY_BYTES*8-1:0] key_flat;
  logic [KW-1:0] key_last;
  logic [7:0]    key_byte;

  logic [rc4_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]    i_r, i_nxt, j_r, j_nxt;
  logic [7:0]    si_r, si_nxt, sj_r, sj_nxt, t_r, t_nxt;
  logic [7:0]    data_r, data_nxt, res_r, res_nxt, out_r, out_nxt;
  logic [KW-1:0] kidx_r, kidx_nxt;

  logic          p_we, s_we;
  logic [AW-1:0] p_waddr, p_raddr, cnt_addr;
  logic [7:0]    p_wdata, p_rdata, s_rdata;
  logic [7:0]    sum_j, ks, res_now;

  assign key_flat = key_r;
  assign key_byte = key_flat[{kidx_r, 3'b000} +: 8];
  assign cnt_addr = cnt_r[AW-1:0];
  assign sum_j    = j_r + p_rdata;

  always_comb begin
    if (key_len_r == '0) begin
      key_last = '0;
    end else if (key_len_r > rc4_pkg::KEY_LEN_W'(rc4_pkg::MAX_KEY_BYTES)) begin
      key_last = KW'(rc4_pkg::MAX_KEY_BYTES - 1);
    end else begin
      key_last = KW'(key_len_r - 1'b1);
    end
  end

  always_comb begin
    if (t_r == j_r) begin
      ks = si_r;
    end else if (t_r == i_r) begin
      ks = sj_r;
    end else begin
      ks = p_rdata;
    end
  end

  assign res_now = data_r ^ ks;

  always_comb begin
    p_we     = 1'b0;
    s_we     = 1'b0;
    p_waddr  = cnt_addr;
    p_wdata  = cnt_addr;
    p_raddr  = cnt_addr;
    i_nxt    = i_r;
    j_nxt    = j_r;
    si_nxt   = si_r;
    sj_nxt   = sj_r;
    t_nxt    = t_r;
    data_nxt = data_r;
    res_nxt  = res_r;
    kidx_nxt = kidx_r;
    case (cmd.op)
      rc4_pkg::OP_D_RDI: begin
        i_nxt    = i_r + 8'd1;
        p_raddr  = i_r + 8'd1;
        data_nxt = in_data;
      end
      rc4_pkg::OP_D_RDJ: begin
        si_nxt  = p_rdata;
        j_nxt   = sum_j;
        p_raddr = sum_j;
      end
      rc4_pkg::OP_D_WRI: begin
        sj_nxt  = p_rdata;
        p_we    = 1'b1;
        p_waddr = i_r;
        p_wdata = p_rdata;
        p_raddr = si_r + p_rdata;
        t_nxt   = si_r + p_rdata;
      end
      rc4_pkg::OP_D_WRJ: begin
        p_we    = 1'b1;
        p_waddr = j_r;
        p_wdata = si_r;
        res_nxt = res_now;
      end
      rc4_pkg::OP_FILL_ID: begin
        p_we     = 1'b1;
        s_we     = 1'b1;
        j_nxt    = '0;
        kidx_nxt = '0;
      end
      rc4_pkg::OP_FILL_FF: begin
        p_we    = 1'b1;
        s_we    = 1'b1;
        p_wdata = rc4_pkg::BURN_VALUE;
      end
      rc4_pkg::OP_COPY: begin
        p_we    = (cnt_r != '0);
        p_waddr = cnt_addr - 1'b1;
        p_wdata = s_rdata;
      end
      rc4_pkg::OP_K_RDN: begin
        p_raddr = cnt_addr;
      end
      rc4_pkg::OP_K_RDJ: begin
        si_nxt  = p_rdata;
        j_nxt   = sum_j + key_byte;
        p_raddr = sum_j + key_byte;
      end
      rc4_pkg::OP_K_WRN: begin
        p_we    = 1'b1;
        s_we    = 1'b1;
        p_wdata = p_rdata;
      end
      rc4_pkg::OP_K_WRJ: begin
        p_we     = 1'b1;
        s_we     = 1'b1;
        p_waddr  = j_r;
        p_wdata  = si_r;
        kidx_nxt = (kidx_r == key_last) ? '0 : kidx_r + 1'b1;
      end
      default: begin
      end
    endcase
    if (cmd.idx_clr) begin
      i_nxt = '0;
      j_nxt = '0;
    end
  end

  always_comb begin
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
    if (cmd.out_new) begin
      out_nxt = res_now;
    end else if (cmd.out_held) begin
      out_nxt = res_r;
    end else begin
      out_nxt = out_r;
    end
  end

  assign stat.cnt_last = (cnt_r == rc4_pkg::CNT_W'(rc4_pkg::TAB_DEPTH - 1));
  assign stat.cnt_done = (cnt_r == rc4_pkg::CNT_W'(rc4_pkg::TAB_DEPTH));
  assign out_byte      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      key_len_r <= rc4_pkg::KEY_LEN_RESET;
      cnt_r     <= '0;
      i_r       <= '0;
      j_r       <= '0;
      kidx_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rc4_pkg::CFG_KEY_W0:  key_r[0]  <= cfg_wdata;
          rc4_pkg::CFG_KEY_W1:  key_r[1]  <= cfg_wdata;
          rc4_pkg::CFG_KEY_W2:  key_r[2]  <= cfg_wdata;
          rc4_pkg::CFG_KEY_W3:  key_r[3]  <= cfg_wdata;
          rc4_pkg::CFG_KEY_LEN: key_len_r <= cfg_wdata[rc4_pkg::KEY_LEN_W-1:0];
          default: begin
          end
        endcase
      end
      cnt_r  <= cnt_nxt;
      i_r    <= i_nxt;
      j_r    <= j_nxt;
      kidx_r <= kidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r   <= si_nxt;
    sj_r   <= sj_nxt;
    t_r    <= t_nxt;
    data_r <= data_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  rc4_ram #(
    .WIDTH(8),
    .DEPTH(rc4_pkg::TAB_DEPTH)
  ) u_perm (
    .clk  (clk),
    .we   (p_we),
    .waddr(p_waddr),
    .wdata(p_wdata),
    .raddr(p_raddr),
    .rdata(p_rdata)
  );

  // saved copy is written alongside the permutation during schedule and burn
  rc4_ram #(
    .WIDTH(8),
    .DEPTH(rc4_pkg::TAB_DEPTH)
  ) u_saved (
    .clk  (clk),
    .we   (s_we),
    .waddr(p_waddr),
    .wdata(p_wdata),
    .raddr(cnt_addr),
    .rdata(s_rdata)
  );

endmodule

/* sim/rc4_keystream_checker.sv */
`timescale 1ns / 1ps

module rc4_keystream_checker
  import rc4_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic [1:0]            in_tuser,   // [1:0] kind
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [7:0]            out_tdata,  // [7:0] out_byte
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [KEY_WORD_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    bytes_pending,
  output int                    bytes_checked
);

  logic [KEY_WORD_W-1:0] key_word [KEY_WORDS];
  logic [KEY_LEN_W-1:0]  key_len;
  logic [7:0]            sbox [TAB_DEPTH];
  logic [7:0]            sbox_saved [TAB_DEPTH];
  logic [7:0]            ks_i;
  logic [7:0]            ks_j;
  logic                  is_keyed;
  logic [7:0]            expected_bytes [$];
  int                    fail_tally = 0;
  int                    checked_tally = 0;

  function automatic logic [7:0] key_byte_at(int k);
    return key_word[k / 8][8 * (k % 8) +: 8];
  endfunction

  task automatic run_key_schedule();
    int         len;
    logic [7:0] j;
    logic [7:0] held;
    len = key_len;
    if (len == 0) len = 1;
    if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
    for (int n = 0; n < TAB_DEPTH; n++) sbox[n] = 8'(n);
    j = '0;
    for (int n = 0; n < TAB_DEPTH; n++) begin
      held    = sbox[n];
      j       = j + held + key_byte_at(n % len);
      sbox[n] = sbox[j];
      sbox[j] = held;
    end
    sbox_saved = sbox;
    ks_i       = '0;
    ks_j       = '0;
    is_keyed   = 1'b1;
  endtask

  function automatic logic [7:0] next_cipher_byte(logic [7:0] data);
    logic [7:0] si;
    logic [7:0] sj;
    ks_i       = ks_i + 8'd1;
    si         = sbox[ks_i];
    ks_j       = ks_j + si;
    sj         = sbox[ks_j];
    sbox[ks_i] = sj;
    sbox[ks_j] = si;
    return data ^ sbox[8'(si + sj)];
  endfunction

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      foreach (key_word[w]) key_word[w] = '0;
      key_len  = KEY_LEN_RESET;
      ks_i     = '0;
      ks_j     = '0;
      is_keyed = 1'b0;
      foreach (sbox[n]) begin
        sbox[n]       = '0;
        sbox_saved[n] = '0;
      end
      expected_bytes.delete();
    end else begin
      // a result never leaves in the cycle its transaction is taken
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: out_byte %02h", out_tdata);
          fail_tally++;
        end else begin
          want = expected_bytes.pop_front();
          checked_tally++;
          if (out_tdata !== want) begin
            $error("out_byte mismatch: expected %02h, actual %02h", want, out_tdata);
            fail_tally++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_W0, CFG_KEY_W1, CFG_KEY_W2, CFG_KEY_W3: begin
            key_word[cfg_index[1:0]] = cfg_wdata;
          end
          CFG_KEY_LEN: begin
            key_len = cfg_wdata[KEY_LEN_W-1:0];
          end
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        case (kind_t'(in_tuser))
          KIND_DATA: begin
            if (is_keyed) expected_bytes.push_back(next_cipher_byte(in_tdata));
          end
          KIND_SCHEDULE: begin
            run_key_schedule();
          end
          KIND_REWIND: begin
            sbox = sbox_saved;
            ks_i = '0;
            ks_j = '0;
          end
          default: begin
            foreach (sbox[n]) begin
              sbox[n]       = BURN_VALUE;
              sbox_saved[n] = BURN_VALUE;
            end
          end
        endcase
      end
    end
    mismatches    <= fail_tally;
    bytes_pending <= expected_bytes.size();
    bytes_checked <= checked_tally;
  end

endmodule

/* sim/tb_rc4_stream_cipher.sv */
`timescale 1ns / 1ps

module tb_rc4_stream_cipher;
  import rc4_pkg::*;

  localparam int KEY_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 118;
  localparam int IDLE_PCT        = 21;
  localparam int QUIET_CYCLES    = 1400;
  localparam int RX_HOLD_CYCLES  = 400;
  localparam int HOLD_START_ITEM = 4;
  localparam int HOLD_DATA_ITEMS = 40;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_KEY_LEN + 3'd1;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [KEY_WORD_W-1:0] cfg_wdata;

  int mismatches;
  int bytes_pending;
  int bytes_checked;

  bit calm        = 1'b0;
  bit rx_hold_req = 1'b0;
  int n_items     = 0;
  int n_sched     = 0;
  int n_rewind    = 0;
  int n_burn      = 0;
  int n_keys      = 0;

  rc4_stream_cipher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  rc4_keystream_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .bytes_pending (bytes_pending),
    .bytes_checked (bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic push_item(kind_t k, logic [7:0] d);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_items++;
    case (k)
      KIND_SCHEDULE: n_sched++;
      KIND_REWIND:   n_rewind++;
      KIND_BURN:     n_burn++;
      default: ;
    endcase
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [KEY_WORD_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_key(logic [KEY_WORD_W-1:0] words [KEY_WORDS],
                          logic [KEY_LEN_W-1:0] klen);
    for (int w = 0; w < KEY_WORDS; w++) cfg_write(CFG_KEY_W0 + CFG_IDX_W'(w), words[w]);
    cfg_write(CFG_KEY_LEN, KEY_WORD_W'(klen));
    // out-of-range index must be ignored
    cfg_write(CFG_SPARE + CFG_IDX_W'($urandom_range(2)), {$urandom, $urandom});
    cfg_we <= 1'b0;
    @(posedge clk);
    n_keys++;
  endtask

  // bytes_pending is registered, so look at it from the next edge on
  task automatic wait_drained();
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // result side: random back-pressure, one long hold-off on request
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (rx_hold_req && !hold_done) begin
        out_tready <= 1'b0;
        hold_left  = RX_HOLD_CYCLES - 1;
        hold_done  = 1'b1;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("rc4_stream_cipher verification failed");
    $finish;
  end

  initial begin
    logic [KEY_WORD_W-1:0] words [KEY_WORDS];
    logic [KEY_LEN_W-1:0]  klen;
    int                    r;
    kind_t                 k;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = KIND_DATA;
    cfg_we    = 1'b0;
    cfg_index = CFG_KEY_W0;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero-length key, unkeyed data, burn/rewind corners
    foreach (words[w]) words[w] = {$urandom, $urandom};
    load_key(words, 6'd0);
    push_item(KIND_DATA, 8'h00);
    push_item(KIND_DATA, 8'hFF);
    push_item(KIND_BURN, 8'h00);
    push_item(KIND_DATA, 8'hA5);
    push_item(KIND_SCHEDULE, 8'hFF);
    push_item(KIND_DATA, 8'h00);
    push_item(KIND_DATA, 8'hFF);
    push_item(KIND_DATA, 8'h5A);
    push_item(KIND_DATA, 8'hA5);
    push_item(KIND_DATA, 8'h01);
    push_item(KIND_DATA, 8'h80);
    push_item(KIND_REWIND, 8'h00);
    push_item(KIND_DATA, 8'h00);
    push_item(KIND_DATA, 8'hFF);
    push_item(KIND_BURN, 8'h00);
    push_item(KIND_DATA, 8'h00);
    push_item(KIND_DATA, 8'h3C);
    push_item(KIND_REWIND, 8'h00);
    push_item(KIND_DATA, 8'h7E);
    push_item(KIND_SCHEDULE, 8'h00);
    push_item(KIND_DATA, 8'h11);

    for (int phase = 0; phase < KEY_PHASES; phase++) begin
      in_tvalid <= 1'b0;
      wait_drained();
      calm = (phase == 3);
      foreach (words[w]) begin
        case (phase)
          0:       words[w] = '0;
          1:       words[w] = '1;
          default: words[w] = {$urandom, $urandom};
        endcase
      end
      case (phase)
        0:       klen = 6'd1;
        1:       klen = 6'd32;
        2:       klen = 6'd63;
        3:       klen = 6'd33;
        4:       klen = 6'd16;
        default: klen = KEY_LEN_W'($urandom_range(1, MAX_KEY_BYTES));
      endcase
      load_key(words, klen);
      push_item(KIND_SCHEDULE, 8'($urandom));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 2 && n == ITEMS_PER_PHASE / 2) begin
          in_tvalid <= 1'b0;
          wait_drained();
        end
        // hold off the receiver once the key schedule is done, with data only
        if (phase == 1 && n == HOLD_START_ITEM) rx_hold_req = 1'b1;
        r = $urandom_range(99);
        if (phase == 1 && n < HOLD_DATA_ITEMS) r = 0;
        if (r < 88)      k = KIND_DATA;
        else if (r < 91) k = KIND_SCHEDULE;
        else if (r < 97) k = KIND_REWIND;
        else             k = KIND_BURN;
        push_item(k, 8'($urandom));
      end
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;
    wait_drained();

    $display("Sent %0d transactions under %0d key settings: %0d schedules, %0d rewinds, %0d burns",
             n_items, n_keys, n_sched, n_rewind, n_burn);
    $display("Checked %0d cipher bytes, %0d mismatches", bytes_checked, mismatches);
    if (mismatches == 0) begin
      $display("rc4_stream_cipher verification clean");
    end else begin
      $display("rc4_stream_cipher verification failed");
    end
    $finish;
  end

endmodule
